// File: hw/rtl/prg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prg_pkg
// Shared widths, defaults and register indexes of the pinhole ray generator.
// ----------------------------------------------------------------------------
package prg_pkg;

  localparam int COMP_W       = 20;
  localparam int DIR_W        = 18;
  localparam int REG_W        = 3 * COMP_W;
  localparam int PIX_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int A_W          = 30;
  localparam int FRAC_W       = 16;
  localparam int SCREEN_W_DEF = 1024;
  localparam int SCREEN_H_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_LEFT     = 2'd0,
    CFG_TOP_RIGHT    = 2'd1,
    CFG_BOTTOM_RIGHT = 2'd2,
    CFG_EYE          = 2'd3
  } cfg_idx_t;

endpackage
`default_nettype wire

// File: hw/rtl/prg_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prg_pix_if
// Pixel coordinate channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prg_pix_if import prg_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/prg_ray_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prg_ray_if
// Primary ray channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prg_ray_if import prg_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] origin_x;
  logic signed [COMP_W-1:0] origin_y;
  logic signed [COMP_W-1:0] origin_z;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic signed [DIR_W-1:0]  dir_z;
  logic                     degenerate;

  modport source (output valid, output origin_x, output origin_y, output origin_z,
                  output dir_x, output dir_y, output dir_z, output degenerate,
                  input ready);
  modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, input degenerate,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pinhole_ray_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_ray_generator
// Pinhole camera primary ray generation: one unit ray per pixel.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock while the output is not stalled, and
// returns one ray per pixel in order. The 32-stage square root and the
// 17-stage divider normalize the direction; every stage holds its own item,
// so a stall at the output only fills empty stages before the input is held
// off. The ray origin is the eye position register, and the corner registers
// must be written while no item is in flight.
module pinhole_ray_generator import prg_pkg::*; #(
  parameter int SCREEN_W = SCREEN_W_DEF,
  parameter int SCREEN_H = SCREEN_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_data,
  prg_pix_if.sink              in_pix,
  prg_ray_if.source            out_ray
);

  localparam int WB    = $clog2(SCREEN_W + 1);
  localparam int HB    = $clog2(SCREEN_H + 1);
  localparam int WHB   = $clog2(SCREEN_W * SCREEN_H + 1);
  localparam int DW    = COMP_W + 1;
  localparam int PW    = DW + PIX_W + 1;
  localparam int BW    = DW + WHB + 1;
  localparam int T1W   = PW + HB + 1;
  localparam int T2W   = PW + WB + 1;
  localparam int NWM   = (BW > T1W) ? ((BW > T2W) ? BW : T2W) : ((T1W > T2W) ? T1W : T2W);
  localparam int NW    = NWM + 2;
  localparam int MW    = NW - 1;
  localparam int SHW   = $clog2(MW - A_W + 1);
  localparam int SQW   = 2 * A_W;
  localparam int SW    = SQW + 2;
  localparam int RW    = SW + 1;
  localparam int LW    = A_W + 1;
  localparam int QW    = FRAC_W + 1;
  localparam int NUMW  = A_W + FRAC_W + 1;
  localparam int SQ_N  = RW / 2 + 1;
  localparam int ST_SQ0 = 9;
  localparam int ST_PRE = ST_SQ0 + SQ_N;
  localparam int ST_DV0 = ST_PRE + 1;
  localparam int ST_OUT = ST_DV0 + QW;
  localparam int NS     = ST_OUT + 1;

  localparam logic signed [HB:0]  H_S  = (HB + 1)'(SCREEN_H);
  localparam logic signed [WB:0]  W_S  = (WB + 1)'(SCREEN_W);
  localparam logic signed [WHB:0] WH_S = (WHB + 1)'(SCREEN_W * SCREEN_H);
  localparam logic [QW-1:0]       ONE_Q16 = QW'(1) << FRAC_W;

  typedef struct packed {
    logic [2:0][A_W-1:0] a;
    logic [2:0]          neg;
    logic                zero;
  } carry_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } flag_t;

  function automatic logic signed [DW-1:0] comp_ext(logic [REG_W-1:0] r, int k);
    logic [COMP_W-1:0] c;
    c = r[COMP_W*k +: COMP_W];
    return {c[COMP_W-1], c};
  endfunction

  logic [REG_W-1:0] tl_r, tr_r, br_r, eye_r;
  logic signed [DW-1:0] d0_r [3];
  logic signed [BW-1:0] base_r [3];

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   en;

  logic [PIX_W-1:0]       px_r, py_r;
  logic signed [PW-1:0]   p1_r [3];
  logic signed [PW-1:0]   p2_r [3];
  logic signed [T1W-1:0]  t1_r [3];
  logic signed [T2W-1:0]  t2_r [3];
  logic signed [NW-1:0]   n_r [3];
  logic [MW-1:0]          mag4_r [3];
  logic [2:0]             neg4_r;
  logic [MW-1:0]          mag5_r [3];
  flag_t                  f5_r;
  logic [SHW-1:0]         sh5_r;
  logic [SHW-1:0]         sh_nxt;
  logic [MW-1:0]          mag_or;
  carry_t                 c6_r, c7_r, c8_r;
  logic [SQW-1:0]         sq7_r [3];
  logic [SW-1:0]          s8_r;

  carry_t                 sq_c_r   [SQ_N];
  logic [SW-1:0]          sq_rem_r [SQ_N];
  logic [RW-1:0]          sq_res_r [SQ_N];

  flag_t                  pre_f_r;
  logic [NUMW-1:0]        pre_num_r [3];
  logic [LW-1:0]          pre_len_r;
  logic [LW-1:0]          len_nxt;

  flag_t                  dv_f_r   [QW];
  logic [LW-1:0]          dv_len_r [QW];
  logic [2:0][NUMW-1:0]   dv_rem_r [QW];
  logic [2:0][QW-1:0]     dv_q_r   [QW];

  logic signed [DIR_W-1:0] dir_r [3];
  logic                    degen_r;

  // Configuration registers and values derived from them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r  <= '0;
      tr_r  <= '0;
      br_r  <= '0;
      eye_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TOP_LEFT:     tl_r  <= cfg_data;
        CFG_TOP_RIGHT:    tr_r  <= cfg_data;
        CFG_BOTTOM_RIGHT: br_r  <= cfg_data;
        CFG_EYE:          eye_r <= cfg_data;
        default:          tl_r  <= tl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d0_r[k]   <= comp_ext(tl_r, k) - comp_ext(eye_r, k);
      base_r[k] <= BW'(d0_r[k]) * BW'(WH_S);
    end
  end

  // Per-stage handshake: a stage loads when it is empty or its successor loads.
  assign en[NS] = out_ray.ready;
  assign v_in   = {v_r[NS-2:0], in_pix.valid};

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_pix.ready = en[0];

  // Stages 0 to 3: exact scaled direction N.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r <= in_pix.pixel_x;
      py_r <= in_pix.pixel_y;
    end
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        p1_r[k] <= PW'(comp_ext(tr_r, k) - comp_ext(tl_r, k)) * PW'($signed({1'b0, px_r}));
        p2_r[k] <= PW'(comp_ext(br_r, k) - comp_ext(tr_r, k)) * PW'($signed({1'b0, py_r}));
      end
    end
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        t1_r[k] <= T1W'(p1_r[k]) * T1W'(H_S);
        t2_r[k] <= T2W'(p2_r[k]) * T2W'(W_S);
      end
    end
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= NW'(base_r[k]) + NW'(t1_r[k]) + NW'(t2_r[k]);
      end
    end
  end

  // Stages 4 to 8: magnitudes, range reduction and sum of squares.
  always_comb begin
    mag_or = mag4_r[0] | mag4_r[1] | mag4_r[2];
    sh_nxt = '0;
    for (int i = A_W; i < MW; i++) begin
      if (mag_or[i]) begin
        sh_nxt = SHW'(i - A_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        neg4_r[k] <= n_r[k][NW-1];
        mag4_r[k] <= MW'(n_r[k][NW-1] ? -n_r[k] : n_r[k]);
      end
    end
    if (en[5]) begin
      mag5_r    <= mag4_r;
      f5_r.neg  <= neg4_r;
      f5_r.zero <= (mag_or == '0);
      sh5_r     <= sh_nxt;
    end
    if (en[6]) begin
      for (int k = 0; k < 3; k++) begin
        c6_r.a[k] <= A_W'(mag5_r[k] >> sh5_r);
      end
      c6_r.neg  <= f5_r.neg;
      c6_r.zero <= f5_r.zero;
    end
    if (en[7]) begin
      for (int k = 0; k < 3; k++) begin
        sq7_r[k] <= SQW'(c6_r.a[k]) * SQW'(c6_r.a[k]);
      end
      c7_r <= c6_r;
    end
    if (en[8]) begin
      s8_r <= SW'(sq7_r[0]) + SW'(sq7_r[1]) + SW'(sq7_r[2]);
      c8_r <= c7_r;
    end
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * j);
    logic [SW-1:0] rem_in;
    logic [RW-1:0] res_in;
    logic [RW-1:0] trial;
    carry_t        c_in;

    if (j == 0) begin : g_first
      assign rem_in = s8_r;
      assign res_in = '0;
      assign c_in   = c8_r;
    end else begin : g_next
      assign rem_in = sq_rem_r[j-1];
      assign res_in = sq_res_r[j-1];
      assign c_in   = sq_c_r[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en[ST_SQ0 + j]) begin
        sq_c_r[j] <= c_in;
        if (RW'(rem_in) >= trial) begin
          sq_rem_r[j] <= rem_in - SW'(trial);
          sq_res_r[j] <= (res_in >> 1) + BIT;
        end else begin
          sq_rem_r[j] <= rem_in;
          sq_res_r[j] <= res_in >> 1;
        end
      end
    end
  end

  // Rounded dividends for the normalization.
  assign len_nxt = (sq_res_r[SQ_N-1][LW-1:0] == '0) ? LW'(1) : sq_res_r[SQ_N-1][LW-1:0];

  always_ff @(posedge clk) begin
    if (en[ST_PRE]) begin
      for (int k = 0; k < 3; k++) begin
        pre_num_r[k] <= NUMW'({sq_c_r[SQ_N-1].a[k], {FRAC_W{1'b0}}}) + NUMW'(len_nxt >> 1);
      end
      pre_len_r     <= len_nxt;
      pre_f_r.neg   <= sq_c_r[SQ_N-1].neg;
      pre_f_r.zero  <= sq_c_r[SQ_N-1].zero;
    end
  end

  // Restoring divider, one quotient bit per stage for all three components.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [2:0][NUMW-1:0] rem_in;
    logic [2:0][QW-1:0]   q_in;
    logic [LW-1:0]        len_in;
    flag_t                f_in;
    logic [NUMW-1:0]      dsr;

    if (j == 0) begin : g_first
      assign rem_in = {pre_num_r[2], pre_num_r[1], pre_num_r[0]};
      assign q_in   = '0;
      assign len_in = pre_len_r;
      assign f_in   = pre_f_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign len_in = dv_len_r[j-1];
      assign f_in   = dv_f_r[j-1];
    end

    assign dsr = NUMW'(len_in) << SH;

    always_ff @(posedge clk) begin
      if (en[ST_DV0 + j]) begin
        dv_len_r[j] <= len_in;
        dv_f_r[j]   <= f_in;
        for (int k = 0; k < 3; k++) begin
          if (rem_in[k] >= dsr) begin
            dv_rem_r[j][k] <= rem_in[k] - dsr;
            dv_q_r[j][k]   <= q_in[k] | (QW'(1) << SH);
          end else begin
            dv_rem_r[j][k] <= rem_in[k];
            dv_q_r[j][k]   <= q_in[k];
          end
        end
      end
    end
  end

  // Output register: saturation, sign and the zero-length case.
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_f_r[QW-1].zero) begin
          dir_r[k] <= '0;
        end else if (dv_f_r[QW-1].neg[k]) begin
          dir_r[k] <= -DIR_W'((dv_q_r[QW-1][k] > ONE_Q16) ? ONE_Q16 : dv_q_r[QW-1][k]);
        end else begin
          dir_r[k] <= DIR_W'((dv_q_r[QW-1][k] > ONE_Q16) ? ONE_Q16 : dv_q_r[QW-1][k]);
        end
      end
      degen_r <= dv_f_r[QW-1].zero;
    end
  end

  assign out_ray.valid      = v_r[NS-1];
  assign out_ray.origin_x   = eye_r[0*COMP_W +: COMP_W];
  assign out_ray.origin_y   = eye_r[1*COMP_W +: COMP_W];
  assign out_ray.origin_z   = eye_r[2*COMP_W +: COMP_W];
  assign out_ray.dir_x      = dir_r[0];
  assign out_ray.dir_y      = dir_r[1];
  assign out_ray.dir_z      = dir_r[2];
  assign out_ray.degenerate = degen_r;

`ifndef SYNTH
  a_accept_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  a_degenerate_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_ray.valid && out_ray.degenerate |->
      out_ray.dir_x == '0 && out_ray.dir_y == '0 && out_ray.dir_z == '0)
    else $error("degenerate ray carries a nonzero direction");

  a_unit_has_major_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_ray.valid && !out_ray.degenerate |->
      out_ray.dir_x > 18'sd32768 || out_ray.dir_x < -18'sd32768 ||
      out_ray.dir_y > 18'sd32768 || out_ray.dir_y < -18'sd32768 ||
      out_ray.dir_z > 18'sd32768 || out_ray.dir_z < -18'sd32768)
    else $error("normalized direction is too short");

  a_dir_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ray.valid |->
      out_ray.dir_x <= 18'sd65536 && out_ray.dir_x >= -18'sd65536 &&
      out_ray.dir_y <= 18'sd65536 && out_ray.dir_y >= -18'sd65536 &&
      out_ray.dir_z <= 18'sd65536 && out_ray.dir_z >= -18'sd65536)
    else $error("direction component beyond unit range");
`endif

endmodule
`default_nettype wire
